### design/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is applied
`define FPW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset
`define FPW_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/fpw_pkg.sv
package fpw_pkg;

    // Default store geometry
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    // Request opcodes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_FILL  = 2'd1;
    localparam logic [1:0] OP_BLEND = 2'd2;
    localparam logic [1:0] OP_COPY  = 2'd3;

    // Pixel formats
    localparam logic [2:0] FMT_RGB565 = 3'd0;
    localparam logic [2:0] FMT_RGB888 = 3'd1;
    localparam logic [2:0] FMT_ARGB   = 3'd2;
    localparam logic [2:0] FMT_BGRA   = 3'd3;
    localparam logic [2:0] FMT_MONO   = 3'd4;

    // What the datapath writes back
    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_BLEND = 3'd1;
    localparam logic [2:0] MODE_PACK  = 3'd2;
    localparam logic [2:0] MODE_LUMA  = 3'd3;
    localparam logic [2:0] MODE_COPY  = 3'd4;

    // Register indexes (word address)
    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // BT.601 luma weights, scaled by 1000
    localparam int LUMA_R      = 299;
    localparam int LUMA_G      = 587;
    localparam int LUMA_B      = 114;
    localparam int LUMA_THRESH = 128 * 1000;

    localparam logic [7:0] COV_HALF     = 8'h80;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic [7:0]         coverage;
        logic [31:0]        source_pixel;
    } t_pix_req;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic        written;
        logic        clipped;
    } t_pix_rsp;

    // Operation held for the datapath while a request is in flight
    typedef struct packed {
        logic [2:0]  fmt;
        logic [2:0]  mode;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  weight;
        logic [31:0] src;
    } t_op_ctl;

    // floor(s / 255) for s up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] s);
        logic [16:0] t;
        t = {1'b0, s} + 17'(s[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    // Native layout; k is the alpha byte for the 32-bit formats
    function automatic logic [31:0] pack_pixel(input logic [2:0] fmt,
                                               input logic [7:0] r,
                                               input logic [7:0] g,
                                               input logic [7:0] b,
                                               input logic [7:0] k);
        logic [31:0] v;
        unique case (fmt)
            FMT_RGB565: v = {16'd0, r[7:3], g[7:2], b[7:3]};
            FMT_RGB888: v = {8'd0, b, g, r};
            FMT_ARGB:   v = {b, g, r, k};
            default:    v = {k, r, g, b};
        endcase
        return v;
    endfunction

    // Raw copy trimmed to the format's width
    function automatic logic [31:0] copy_mask(input logic [2:0] fmt, input logic [31:0] src);
        logic [31:0] v;
        unique case (fmt)
            FMT_RGB565: v = {16'd0, src[15:0]};
            FMT_RGB888: v = {8'd0, src[23:0]};
            FMT_ARGB:   v = src;
            FMT_BGRA:   v = src;
            FMT_MONO:   v = {31'd0, src[0]};
            default:    v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### design/framebuffer_pixel_writer.sv
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ----------------------
// request   in         i_in_valid / o_in_stall   i_in  (t_pix_req)
// result    out        o_out_valid / i_out_stall o_out (t_pix_rsp)
// config    in         psel/penable/pwrite       paddr, pwdata, prdata
//
// Each request passes through accept with store read issued, a product stage on the
// read data, then finish with write-back and the result loaded into the output register.
// One request is in flight at a time; the next is taken once the previous reaches the
// output register, even while that result is still stalled.
// After reset all MAX_WIDTH*MAX_HEIGHT store entries (4096 by default) are swept to
// zero with o_in_stall high; config writes are taken throughout.
module framebuffer_pixel_writer #(
    parameter int MAX_WIDTH  = fpw_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fpw_pkg::MAX_HEIGHT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  fpw_pkg::t_pix_req i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output fpw_pkg::t_pix_rsp o_out,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [15:0] LIM_W = 16'(MAX_WIDTH);
    localparam logic [15:0] LIM_H = 16'(MAX_HEIGHT);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [2:0]       r_fmt;
    logic [6:0]       r_dw;
    logic [6:0]       r_dh;
    logic [1:0]       r_state, n_state;
    fpw_pkg::t_op_ctl r_ctl, n_ctl;
    logic             r_clip;
    logic             r_wr;
    logic [AW-1:0]    r_addr, n_addr;
    logic             r_out_valid;
    fpw_pkg::t_pix_rsp r_out;

    logic        cfg_we;
    logic        in_acc;
    logic        out_free;
    logic        fin_go;
    logic        store_busy;
    logic [31:0] rd_data;
    logic [31:0] new_pixel;
    logic [15:0] x_u, y_u;
    logic        clip;
    logic        is_mono, is_colour;

    // Configuration registers
    assign cfg_we = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= fpw_pkg::FMT_RGB565;
            r_dw  <= 7'd64;
            r_dh  <= 7'd64;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                fpw_pkg::REG_FORMAT: r_fmt <= pwdata[2:0];
                fpw_pkg::REG_WIDTH:  r_dw  <= pwdata[6:0];
                fpw_pkg::REG_HEIGHT: r_dh  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            fpw_pkg::REG_FORMAT: prdata = {29'd0, r_fmt};
            fpw_pkg::REG_WIDTH:  prdata = {25'd0, r_dw};
            fpw_pkg::REG_HEIGHT: prdata = {25'd0, r_dh};
            default:             prdata = 32'd0;
        endcase
    end

    // Handshakes
    assign o_in_stall = (r_state != ST_IDLE) | store_busy;
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign fin_go     = (r_state == ST_FIN) & out_free;

    // Clip test and linear address
    assign x_u  = i_in.pos_x;
    assign y_u  = i_in.pos_y;
    assign clip = x_u[15] | y_u[15]
                | (x_u >= {9'd0, r_dw}) | (x_u >= LIM_W)
                | (y_u >= {9'd0, r_dh}) | (y_u >= LIM_H);
    assign n_addr = AW'(32'(y_u[14:0]) * 32'(MAX_WIDTH) + 32'(x_u[14:0]));

    assign is_mono   = (r_fmt == fpw_pkg::FMT_MONO);
    assign is_colour = (r_fmt <= fpw_pkg::FMT_BGRA);

    // Decode the request into a write-back mode
    always_comb begin
        n_ctl.fmt    = r_fmt;
        n_ctl.mode   = fpw_pkg::MODE_NONE;
        n_ctl.red    = i_in.red;
        n_ctl.green  = i_in.green;
        n_ctl.blue   = i_in.blue;
        n_ctl.alpha  = i_in.alpha;
        n_ctl.weight = (i_in.opcode == fpw_pkg::OP_FILL) ? i_in.alpha : i_in.coverage;
        n_ctl.src    = i_in.source_pixel;
        unique case (i_in.opcode)
            fpw_pkg::OP_FILL: begin
                if (is_mono) begin
                    n_ctl.mode = fpw_pkg::MODE_LUMA;
                end else if (is_colour) begin
                    n_ctl.mode = (i_in.alpha < fpw_pkg::ALPHA_OPAQUE) ?
                                 fpw_pkg::MODE_BLEND : fpw_pkg::MODE_PACK;
                end
            end
            fpw_pkg::OP_BLEND: begin
                if (i_in.coverage != 8'd0) begin
                    if (is_mono) begin
                        if (i_in.coverage >= fpw_pkg::COV_HALF) begin
                            n_ctl.mode = fpw_pkg::MODE_LUMA;
                        end
                    end else if (is_colour) begin
                        n_ctl.mode = fpw_pkg::MODE_BLEND;
                    end
                end
            end
            fpw_pkg::OP_COPY: begin
                if (is_colour | is_mono) begin
                    n_ctl.mode = fpw_pkg::MODE_COPY;
                end
            end
            default: ;
        endcase
        if (clip) begin
            n_ctl.mode = fpw_pkg::MODE_NONE;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_acc) n_state = ST_MUL;
            ST_MUL:  n_state = ST_FIN;
            ST_FIN:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (~i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request hold registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ctl  <= n_ctl;
            r_clip <= clip;
            r_wr   <= (n_ctl.mode != fpw_pkg::MODE_NONE);
            r_addr <= n_addr;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_out.pixel_value <= r_clip ? 32'd0 : new_pixel;
            r_out.written     <= r_wr;
            r_out.clipped     <= r_clip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    fpw_store #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (in_acc),
        .i_rd_addr(n_addr),
        .o_rd_data(rd_data),
        .i_wr_en  (fin_go & r_wr),
        .i_wr_addr(r_addr),
        .i_wr_data(new_pixel),
        .o_busy   (store_busy)
    );

    fpw_blend u_blend (
        .i_clk   (i_clk),
        .i_mul_en(r_state == ST_MUL),
        .i_ctl   (r_ctl),
        .i_dst   (rd_data),
        .o_pixel (new_pixel)
    );

endmodule

### design/fpw_store.sv
module fpw_store #(
    parameter int DEPTH = fpw_pkg::MAX_WIDTH_DEF * fpw_pkg::MAX_HEIGHT_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [31:0]   o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_data,
    output logic          o_busy
);

    logic [31:0]   r_mem [DEPTH];
    logic [31:0]   r_rd_data;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // Clearing sweep after reset, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Single write port, shared by the sweep
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= 32'd0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

### design/fpw_blend.sv
module fpw_blend (
    input  logic             i_clk,
    input  logic             i_mul_en,
    input  fpw_pkg::t_op_ctl i_ctl,
    input  logic [31:0]      i_dst,
    output logic [31:0]      o_pixel
);

    logic [7:0]  d_r, d_g, d_b;
    logic [7:0]  w_inv;
    logic [15:0] r_ps_r, r_ps_g, r_ps_b;
    logic [15:0] r_pd_r, r_pd_g, r_pd_b;
    logic [17:0] r_luma;
    logic [7:0]  mix_r, mix_g, mix_b;
    logic [7:0]  keep;
    logic        luma_on;

    // Destination channels in the current layout
    always_comb begin
        unique case (i_ctl.fmt)
            fpw_pkg::FMT_RGB565: begin
                d_r = {i_dst[15:11], 3'b000};
                d_g = {i_dst[10:5], 2'b00};
                d_b = {i_dst[4:0], 3'b000};
            end
            fpw_pkg::FMT_RGB888: begin
                d_r = i_dst[7:0];
                d_g = i_dst[15:8];
                d_b = i_dst[23:16];
            end
            fpw_pkg::FMT_ARGB: begin
                d_r = i_dst[15:8];
                d_g = i_dst[23:16];
                d_b = i_dst[31:24];
            end
            default: begin
                d_r = i_dst[23:16];
                d_g = i_dst[15:8];
                d_b = i_dst[7:0];
            end
        endcase
    end

    assign w_inv = 8'(fpw_pkg::ALPHA_OPAQUE - i_ctl.weight);

    // Product stage: src*w, dst*(255-w) and the weighted luma
    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_ps_r <= 16'(i_ctl.red) * 16'(i_ctl.weight);
            r_ps_g <= 16'(i_ctl.green) * 16'(i_ctl.weight);
            r_ps_b <= 16'(i_ctl.blue) * 16'(i_ctl.weight);
            r_pd_r <= 16'(d_r) * 16'(w_inv);
            r_pd_g <= 16'(d_g) * 16'(w_inv);
            r_pd_b <= 16'(d_b) * 16'(w_inv);
            r_luma <= 18'(i_ctl.red) * 18'(fpw_pkg::LUMA_R)
                    + 18'(i_ctl.green) * 18'(fpw_pkg::LUMA_G)
                    + 18'(i_ctl.blue) * 18'(fpw_pkg::LUMA_B);
        end
    end

    // Finish: sum, divide by 255, repack
    assign mix_r   = fpw_pkg::div255(16'(r_ps_r + r_pd_r));
    assign mix_g   = fpw_pkg::div255(16'(r_ps_g + r_pd_g));
    assign mix_b   = fpw_pkg::div255(16'(r_ps_b + r_pd_b));
    assign keep    = (i_ctl.fmt == fpw_pkg::FMT_ARGB) ? i_dst[7:0] : i_dst[31:24];
    assign luma_on = (r_luma >= 18'(fpw_pkg::LUMA_THRESH));

    always_comb begin
        unique case (i_ctl.mode)
            fpw_pkg::MODE_BLEND:
                o_pixel = fpw_pkg::pack_pixel(i_ctl.fmt, mix_r, mix_g, mix_b, keep);
            fpw_pkg::MODE_PACK:
                o_pixel = fpw_pkg::pack_pixel(i_ctl.fmt, i_ctl.red, i_ctl.green,
                                              i_ctl.blue, i_ctl.alpha);
            fpw_pkg::MODE_LUMA:
                o_pixel = {31'd0, luma_on};
            fpw_pkg::MODE_COPY:
                o_pixel = fpw_pkg::copy_mask(i_ctl.fmt, i_ctl.src);
            default:
                o_pixel = i_dst;
        endcase
    end

endmodule

### design/fpw_checker.sv
`include "assert_macros.svh"

module fpw_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input fpw_pkg::t_pix_rsp o_out
);

    // Reset leaves no result and holds off requests for the sweep
    `FPW_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> o_in_stall && !o_out_valid, "busy or result after reset")

    // One request in flight: an accept closes the input next cycle
    `FPW_ASSERT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "second request taken while busy")

    // A clipped result carries no pixel and no write
    `FPW_ASSERT(a_clip_empty, i_clk, i_rst_n, o_out_valid && o_out.clipped |-> o_out.pixel_value == 32'd0 && !o_out.written, "clipped result not empty")

    // A stalled result stays put
    `FPW_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out), "stalled result changed")

endmodule

bind framebuffer_pixel_writer fpw_checker u_fpw_checker (.*);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int FB_W = fpw_pkg::MAX_WIDTH_DEF;
    localparam int FB_H = fpw_pkg::MAX_HEIGHT_DEF;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int N_PH = 10;

    // format codes the block leaves undefined
    localparam logic [2:0] FMT_UNDEF_LO = 3'd5;
    localparam logic [2:0] FMT_UNDEF_HI = 3'd7;

    // one directed request, with its result typed in where it is obvious
    typedef struct {
        fpw_pkg::t_pix_req rq;
        bit                typed_on;
        fpw_pkg::t_pix_rsp rsp;
    } t_dir_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    fpw_pkg::t_pix_req i_in = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    fpw_pkg::t_pix_rsp o_out;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [3:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    // shadow of the block's registers and frame store
    logic [2:0]  fmt_sh = fpw_pkg::FMT_RGB565;
    logic [6:0]  width_sh = 7'd64;
    logic [6:0]  height_sh = 7'd64;
    logic [31:0] fb_sh [FB_W*FB_H] = '{default: '0};

    // expected results, oldest first
    fpw_pkg::t_pix_rsp pix_exp_q [$];
    // typed result for the request now on the bus
    bit                cur_typed = 1'b0;
    fpw_pkg::t_pix_rsp cur_typed_rsp = '0;

    int       err_cnt = 0;
    bit       idle_on = 1'b1;
    int       hold_req = 0;
    t_dir_row dir_tab [$];

    // phase settings: format, width, height, request count, idling
    logic [2:0] ph_fmt [N_PH] = '{fpw_pkg::FMT_RGB565, fpw_pkg::FMT_RGB888, fpw_pkg::FMT_ARGB,
                                  fpw_pkg::FMT_BGRA, fpw_pkg::FMT_MONO, fpw_pkg::FMT_MONO,
                                  FMT_UNDEF_HI, FMT_UNDEF_LO, fpw_pkg::FMT_RGB565,
                                  fpw_pkg::FMT_BGRA};
    int ph_w    [N_PH] = '{64, 64, 16, 1, 64, 7, 64, 127, 127, 64};
    int ph_h    [N_PH] = '{64, 64, 8, 1, 64, 3, 64, 0, 127, 64};
    int ph_cnt  [N_PH] = '{100, 100, 100, 80, 100, 60, 40, 30, 100, 90};
    bit ph_idle [N_PH] = '{1, 0, 1, 1, 1, 0, 1, 1, 1, 1};

    framebuffer_pixel_writer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // truncating src-over of one 8-bit channel
    function automatic logic [7:0] mix8(input logic [7:0] s, input logic [7:0] d,
                                        input logic [7:0] a);
        int acc;
        acc = int'(s) * int'(a) + int'(d) * (255 - int'(a));
        return 8'(acc / 255);
    endfunction

    // BT.601 luma threshold for mono
    function automatic logic luma_on(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b);
        return (int'(r) * fpw_pkg::LUMA_R + int'(g) * fpw_pkg::LUMA_G
                + int'(b) * fpw_pkg::LUMA_B) >= fpw_pkg::LUMA_THRESH;
    endfunction

    // src-over onto a stored entry; alpha byte of 32-bit formats kept
    function automatic logic [31:0] blend_over(input logic [31:0] d, input logic [7:0] r,
                                               input logic [7:0] g, input logic [7:0] b,
                                               input logic [7:0] a);
        logic [7:0]  mr, mg, mb;
        logic [31:0] v;
        case (fmt_sh)
            fpw_pkg::FMT_RGB565: begin
                mr = mix8(r, {d[15:11], 3'b000}, a);
                mg = mix8(g, {d[10:5], 2'b00}, a);
                mb = mix8(b, {d[4:0], 3'b000}, a);
                v = {16'd0, mr[7:3], mg[7:2], mb[7:3]};
            end
            fpw_pkg::FMT_RGB888:
                v = {8'd0, mix8(b, d[23:16], a), mix8(g, d[15:8], a), mix8(r, d[7:0], a)};
            fpw_pkg::FMT_ARGB:
                v = {mix8(b, d[31:24], a), mix8(g, d[23:16], a), mix8(r, d[15:8], a),
                     d[7:0]};
            default:
                v = {d[31:24], mix8(r, d[23:16], a), mix8(g, d[15:8], a),
                     mix8(b, d[7:0], a)};
        endcase
        return v;
    endfunction

    // works out the result of one request and updates the shadow store
    function automatic fpw_pkg::t_pix_rsp predict_pixel(input fpw_pkg::t_pix_req rq);
        fpw_pkg::t_pix_rsp rs;
        int                px, py, ew, eh, idx;
        logic [31:0]       nv;
        bit                wr, is_color;
        rs = '0;
        nv = '0;
        wr = 1'b0;
        px = $signed(rq.pos_x);
        py = $signed(rq.pos_y);
        ew = (width_sh < FB_W) ? int'(width_sh) : FB_W;
        eh = (height_sh < FB_H) ? int'(height_sh) : FB_H;
        if (px < 0 || py < 0 || px >= ew || py >= eh) begin
            rs.clipped = 1'b1;
            return rs;
        end
        idx = py * FB_W + px;
        is_color = (fmt_sh <= fpw_pkg::FMT_BGRA);
        case (rq.opcode)
            fpw_pkg::OP_FILL: begin
                if (fmt_sh == fpw_pkg::FMT_MONO) begin
                    nv = {31'd0, luma_on(rq.red, rq.green, rq.blue)};
                    wr = 1'b1;
                end else if (is_color) begin
                    wr = 1'b1;
                    if (rq.alpha != fpw_pkg::ALPHA_OPAQUE) begin
                        nv = blend_over(fb_sh[idx], rq.red, rq.green, rq.blue, rq.alpha);
                    end else begin
                        case (fmt_sh)
                            fpw_pkg::FMT_RGB565:
                                nv = {16'd0, rq.red[7:3], rq.green[7:2], rq.blue[7:3]};
                            fpw_pkg::FMT_RGB888: nv = {8'd0, rq.blue, rq.green, rq.red};
                            fpw_pkg::FMT_ARGB: nv = {rq.blue, rq.green, rq.red, rq.alpha};
                            default: nv = {rq.alpha, rq.red, rq.green, rq.blue};
                        endcase
                    end
                end
            end
            fpw_pkg::OP_BLEND: begin
                // zero coverage skips; mono needs at least half coverage
                if (rq.coverage != 0) begin
                    if (fmt_sh == fpw_pkg::FMT_MONO) begin
                        if (rq.coverage >= fpw_pkg::COV_HALF) begin
                            nv = {31'd0, luma_on(rq.red, rq.green, rq.blue)};
                            wr = 1'b1;
                        end
                    end else if (is_color) begin
                        nv = blend_over(fb_sh[idx], rq.red, rq.green, rq.blue, rq.coverage);
                        wr = 1'b1;
                    end
                end
            end
            fpw_pkg::OP_COPY: begin
                wr = 1'b1;
                case (fmt_sh)
                    fpw_pkg::FMT_RGB565: nv = {16'd0, rq.source_pixel[15:0]};
                    fpw_pkg::FMT_RGB888: nv = {8'd0, rq.source_pixel[23:0]};
                    fpw_pkg::FMT_ARGB, fpw_pkg::FMT_BGRA: nv = rq.source_pixel;
                    fpw_pkg::FMT_MONO: nv = {31'd0, rq.source_pixel[0]};
                    default: wr = 1'b0;
                endcase
            end
            default: ; // read leaves the entry alone
        endcase
        if (wr) fb_sh[idx] = nv;
        rs.pixel_value = fb_sh[idx];
        rs.written = wr;
        return rs;
    endfunction

    function automatic void add_row(input logic [1:0] op, input int x, input int y,
                                    input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b, input logic [7:0] a,
                                    input logic [7:0] cov, input logic [31:0] src,
                                    input bit typed_on, input logic [31:0] pix,
                                    input bit wr, input bit clip);
        t_dir_row row;
        row.rq.opcode = op;
        row.rq.pos_x = 16'(x);
        row.rq.pos_y = 16'(y);
        row.rq.red = r;
        row.rq.green = g;
        row.rq.blue = b;
        row.rq.alpha = a;
        row.rq.coverage = cov;
        row.rq.source_pixel = src;
        row.typed_on = typed_on;
        row.rsp.pixel_value = pix;
        row.rsp.written = wr;
        row.rsp.clipped = clip;
        dir_tab.push_back(row);
    endfunction

    // offer one request, after a random gap while idling is on, and wait until it is taken
    task automatic send_pix(input fpw_pkg::t_pix_req rq, input bit typed_on,
                            input fpw_pkg::t_pix_rsp typed_rsp);
        int w;
        w = idle_on ? $urandom_range(0, 3) : 0;
        if (w != 0) begin
            i_in_valid <= 1'b0;
            repeat (w) @(posedge i_clk);
        end
        i_in <= rq;
        cur_typed <= typed_on;
        cur_typed_rsp <= typed_rsp;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // write all three registers back to back; psel stays up between them
    task automatic set_mode(input logic [2:0] fmt, input int w, input int h);
        logic [1:0]  regs [3];
        logic [31:0] vals [3];
        regs = '{fpw_pkg::REG_FORMAT, fpw_pkg::REG_WIDTH, fpw_pkg::REG_HEIGHT};
        vals = '{32'(fmt), 32'(w), 32'(h)};
        for (int k = 0; k < 3; k++) begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {regs[k], 2'b00};
            pwdata <= vals[k];
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            case (regs[k])
                fpw_pkg::REG_FORMAT: fmt_sh = vals[k][2:0];
                fpw_pkg::REG_WIDTH: width_sh = vals[k][6:0];
                default: height_sh = vals[k][6:0];
            endcase
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // predict on each accepted request, check each accepted result
    always @(posedge i_clk) begin : pix_check
        fpw_pkg::t_pix_rsp want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                want = predict_pixel(i_in);
                if (cur_typed) want = cur_typed_rsp;
                pix_exp_q.push_back(want);
            end
            if (o_out_valid && !i_out_stall) begin
                if (pix_exp_q.size() == 0) begin
                    if (err_cnt < 10)
                        $display("%0t: unexpected result pix=%08h wr=%0b clip=%0b",
                                 $realtime, o_out.pixel_value, o_out.written, o_out.clipped);
                    err_cnt++;
                end else begin
                    want = pix_exp_q.pop_front();
                    if (o_out.pixel_value !== want.pixel_value ||
                        o_out.written !== want.written ||
                        o_out.clipped !== want.clipped) begin
                        if (err_cnt < 10)
                            $display("%0t: mismatch exp %08h/%0b/%0b got %08h/%0b/%0b",
                                     $realtime, want.pixel_value, want.written,
                                     want.clipped, o_out.pixel_value, o_out.written,
                                     o_out.clipped);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // result side: random stalls after each result while idling is on, one long hold-off on request
    always begin : out_drain
        int w;
        @(posedge i_clk);
        if (hold_req != 0) begin
            w = hold_req;
            hold_req <= 0;
            i_out_stall <= 1'b1;
            repeat (w) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end else if (o_out_valid && !i_out_stall && idle_on) begin
            w = $urandom_range(0, 3);
            if (w != 0) begin
                i_out_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : stim
        fpw_pkg::t_pix_req rq;
        fpw_pkg::t_pix_rsp no_rsp;
        int                ew, eh, hx, hy, sel;
        no_rsp = '0;

        // clipping, reads after reset, copy/fill extremes, alpha and coverage edges
        add_row(fpw_pkg::OP_READ, 0, 0, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 32'h0,
                1, 32'h0, 0, 0);
        add_row(fpw_pkg::OP_READ, 63, 63, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFFFFFF,
                1, 32'h0, 0, 0);
        add_row(fpw_pkg::OP_FILL, -1, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 32'h0,
                1, 32'h0, 0, 1);
        add_row(fpw_pkg::OP_FILL, 0, -32768, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 32'h0,
                1, 32'h0, 0, 1);
        add_row(fpw_pkg::OP_READ, 64, 0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0,
                1, 32'h0, 0, 1);
        add_row(fpw_pkg::OP_COPY, 32767, 5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'hFFFFFFFF,
                1, 32'h0, 0, 1);
        add_row(fpw_pkg::OP_BLEND, 3, 64, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 32'h0,
                1, 32'h0, 0, 1);
        add_row(fpw_pkg::OP_COPY, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'hFFFFFFFF,
                1, 32'hFFFF, 1, 0);
        add_row(fpw_pkg::OP_READ, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0,
                1, 32'hFFFF, 0, 0);
        add_row(fpw_pkg::OP_FILL, 1, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 32'h0,
                1, 32'hFFFF, 1, 0);
        add_row(fpw_pkg::OP_FILL, 2, 0, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 32'h0,
                1, 32'h0, 1, 0);
        add_row(fpw_pkg::OP_FILL, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0,
                0, 32'h0, 0, 0);
        add_row(fpw_pkg::OP_FILL, 1, 0, 8'h00, 8'h80, 8'hFF, 8'h80, 8'h00, 32'h0,
                0, 32'h0, 0, 0);
        add_row(fpw_pkg::OP_FILL, 2, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'h00, 32'h0,
                0, 32'h0, 0, 0);
        add_row(fpw_pkg::OP_BLEND, 0, 0, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 32'h0,
                0, 32'h0, 0, 0);
        add_row(fpw_pkg::OP_BLEND, 1, 0, 8'h12, 8'h34, 8'h56, 8'h00, 8'hFF, 32'h0,
                0, 32'h0, 0, 0);
        add_row(fpw_pkg::OP_BLEND, 2, 0, 8'h00, 8'h00, 8'h00, 8'h7F, 8'h01, 32'h0,
                0, 32'h0, 0, 0);
        add_row(fpw_pkg::OP_BLEND, 3, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 32'h0,
                0, 32'h0, 0, 0);
        add_row(fpw_pkg::OP_COPY, 63, 63, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'h12345678,
                1, 32'h5678, 1, 0);
        add_row(fpw_pkg::OP_READ, 63, 63, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0,
                0, 32'h0, 0, 0);
        add_row(fpw_pkg::OP_FILL, 63, 0, 8'hA5, 8'h5A, 8'hC3, 8'hFF, 8'h00, 32'h0,
                0, 32'h0, 0, 0);
        add_row(fpw_pkg::OP_COPY, 0, 63, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'h00000000,
                1, 32'h0, 1, 0);
        add_row(fpw_pkg::OP_BLEND, 63, 0, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h7F, 32'h0,
                0, 32'h0, 0, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows at the reset configuration
        foreach (dir_tab[k]) send_pix(dir_tab[k].rq, dir_tab[k].typed_on, dir_tab[k].rsp);

        // random phases, reconfigured while idle
        for (int ph = 0; ph < N_PH; ph++) begin
            i_in_valid <= 1'b0;
            while (pix_exp_q.size() != 0) @(posedge i_clk);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            set_mode(ph_fmt[ph], ph_w[ph], ph_h[ph]);
            idle_on = ph_idle[ph];
            if (ph == 0) hold_req <= HOLD_OFF_CYCLES;
            ew = (width_sh < FB_W) ? int'(width_sh) : FB_W;
            eh = (height_sh < FB_H) ? int'(height_sh) : FB_H;
            hx = (ew > 8) ? 8 : ((ew < 1) ? 1 : ew);
            hy = (eh > 4) ? 4 : ((eh < 1) ? 1 : eh);
            for (int n = 0; n < ph_cnt[ph]; n++) begin
                rq.opcode = 2'($urandom_range(0, 3));
                // mostly a small hot area so entries get rewritten
                sel = $urandom_range(0, 9);
                if (sel == 0) begin
                    rq.pos_x = 16'($urandom);
                    rq.pos_y = 16'($urandom);
                end else if (sel == 1) begin
                    rq.pos_x = 16'(ew + int'($urandom_range(0, 2)) - 2);
                    rq.pos_y = 16'(eh + int'($urandom_range(0, 2)) - 2);
                end else begin
                    rq.pos_x = 16'($urandom_range(0, hx - 1));
                    rq.pos_y = 16'($urandom_range(0, hy - 1));
                end
                rq.red = 8'($urandom);
                rq.green = 8'($urandom);
                rq.blue = 8'($urandom);
                sel = $urandom_range(0, 9);
                rq.alpha = (sel < 4) ? fpw_pkg::ALPHA_OPAQUE :
                           ((sel == 4) ? 8'h00 : 8'($urandom));
                sel = $urandom_range(0, 9);
                case (sel)
                    0: rq.coverage = 8'h00;
                    1: rq.coverage = fpw_pkg::COV_HALF - 8'd1;
                    2: rq.coverage = fpw_pkg::COV_HALF;
                    3: rq.coverage = 8'hFF;
                    4: rq.coverage = 8'h01;
                    default: rq.coverage = 8'($urandom);
                endcase
                rq.source_pixel = $urandom;
                send_pix(rq, 1'b0, no_rsp);
            end
        end

        i_in_valid <= 1'b0;
        while (pix_exp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && pix_exp_q.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
